// ----- hw/rtl/mass_weighted_3d_stencil_filter_assert.svh -----
// Assertion macros for the stencil filter
`ifndef MASS_WEIGHTED_3D_STENCIL_FILTER_ASSERT_SVH
`define MASS_WEIGHTED_3D_STENCIL_FILTER_ASSERT_SVH
// implication checked every cycle outside reset
`define MWSF_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define MWSF_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/mwsf_pkg.sv -----
// Package: constants, types and helpers of the stencil filter
package mwsf_pkg;
  localparam int DefMaxSizeX = 64;
  localparam int DefMaxSizeY = 64;
  localparam int DefMaxHalf  = 2;
  localparam int DefFracBits = 16;
  localparam int ZLimit      = 64;
  localparam int NumRegs     = 8;
  localparam int CfgW        = 17;
  localparam int CfgIdxW     = 3;

  localparam logic [CfgIdxW-1:0] REG_SIZE_X = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SIZE_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SIZE_Z = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_HALF   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_W0     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_W1     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_W2     = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_MHD    = 3'd7;

  typedef struct packed {
    logic [30:0] density;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] mag_x;
    logic signed [31:0] mag_y;
    logic signed [31:0] mag_z;
  } cell_in_t;

  typedef struct packed {
    logic [30:0] flt_density;
    logic signed [31:0] flt_vel_x;
    logic signed [31:0] flt_vel_y;
    logic signed [31:0] flt_vel_z;
    logic signed [31:0] flt_mag_x;
    logic signed [31:0] flt_mag_y;
    logic signed [31:0] flt_mag_z;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [5:0] cell_z;
    logic zero_mass;
    logic last_cell;
  } cell_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_RD, ST_WT, ST_MUL1, ST_MUL2, ST_ACC, ST_DIV, ST_DIVRUN,
    ST_OUT
  } state_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction
endpackage

// ----- hw/rtl/mwsf_stream_if.sv -----
// Valid/ready stream interface
interface mwsf_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- hw/rtl/mwsf_divider.sv -----
// Serial restoring divider: signed 64-bit sum by unsigned density sum, Q16 quotient
module mwsf_divider
  import mwsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic signed [63:0] num,
  input  logic [63:0] den,
  output logic        busy,
  output logic [31:0] quo
);
  // 64 integer steps plus 16 fraction steps, one bit a cycle
  logic [6:0]   cnt;
  logic         neg;
  logic [79:0]  dvd;
  logic [64:0]  rem;
  logic [79:0]  q;
  logic [64:0]  trial;
  logic [79:0]  q_next;

  assign trial = {rem[63:0], dvd[79]} - {1'b0, den};
  assign q_next = {q[78:0], ~trial[64]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd80;
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[63];
      dvd <= {(num[63] ? 64'd0 - num : num), 16'd0};
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      dvd <= {dvd[78:0], 1'b0};
      rem <= trial[64] ? {rem[63:0], dvd[79]} : trial;
      q   <= q_next;
    end
  end

  // Integer part at or above 2^15 saturates; so does any oversized result
  always_comb begin
    if (neg) quo = (q[79:31] != '0) ? 32'h80000000 : 32'd0 - q[31:0];
    else     quo = (q[79:31] != '0) ? 32'h7fffffff : q[31:0];
  end
endmodule

// ----- hw/rtl/mass_weighted_3d_stencil_filter.sv -----
// Top level: mass-weighted 3D stencil filter with plane store and shared MAC
//  channel | dir | word                  | handshake
//  in_cell | in  | cell_in_t (7 fields)  | valid/ready
//  out_res | out | cell_out_t            | valid/ready
//  cfg     | in  | we, idx[2:0], data 17 | write at we
// A cell is accepted, then written to the store; a filtered cell then runs ST_RD,
// ST_WT, ST_MUL1, ST_MUL2 and ST_ACC per stencil tap ((2h+1)^3 taps: 27 at h=1),
// paced by the single store read port and the shared multipliers, then the serial
// divider per lane (unused on zero mass) and ST_OUT, held while a result word waits.
// Reset is synchronous; the store keeps its contents and is not cleared.
// A result waits in the output register while the next cell is taken.
module mass_weighted_3d_stencil_filter
  import mwsf_pkg::*;
#(
  parameter int MAX_SIZE_X = DefMaxSizeX,
  parameter int MAX_SIZE_Y = DefMaxSizeY,
  parameter int MAX_HALF   = DefMaxHalf
) (
  input  logic               clk,
  input  logic               rst,
  mwsf_stream_if.sink        in_cell,
  mwsf_stream_if.source      out_res,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [CfgW-1:0]    cfg_data
);
  localparam int Ring = 2 * MAX_HALF + 1;
  localparam int XW = $clog2(MAX_SIZE_X);
  localparam int YW = $clog2(MAX_SIZE_Y);
  localparam int RW = $clog2(Ring);
  localparam int Depth = Ring * MAX_SIZE_Y * MAX_SIZE_X;
  localparam int AW = $clog2(Depth);
  localparam int HW = $clog2(MAX_HALF + 1);
  localparam int OW = $clog2(2 * MAX_HALF + 1) + 1;
  localparam logic [63:0] Round = 64'd1 << (DefFracBits - 1);

  // configuration
  logic [6:0] size_x, size_y, size_z;
  logic [1:0] half_width;
  logic [16:0] w0, w1, w2;
  logic mhd;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= 7'd16; size_y <= 7'd16; size_z <= 7'd16;
      half_width <= 2'd1;
      w0 <= 17'd32768; w1 <= 17'd16384; w2 <= 17'd0;
      mhd <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SIZE_X: size_x <= cfg_data[6:0];
        REG_SIZE_Y: size_y <= cfg_data[6:0];
        REG_SIZE_Z: size_z <= cfg_data[6:0];
        REG_HALF:   half_width <= cfg_data[1:0];
        REG_W0:     w0 <= cfg_data;
        REG_W1:     w1 <= cfg_data;
        REG_W2:     w2 <= cfg_data;
        REG_MHD:    mhd <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  logic [8:0] sx, sy, sz;
  logic [HW:0] h;
  always_comb begin
    sx = (size_x == 7'd0) ? 9'd1 : ({2'd0, size_x} > 9'(MAX_SIZE_X) ? 9'(MAX_SIZE_X)
                                    : {2'd0, size_x});
    sy = (size_y == 7'd0) ? 9'd1 : ({2'd0, size_y} > 9'(MAX_SIZE_Y) ? 9'(MAX_SIZE_Y)
                                    : {2'd0, size_y});
    sz = (size_z == 7'd0) ? 9'd1 : ({2'd0, size_z} > 9'(ZLimit) ? 9'(ZLimit)
                                    : {2'd0, size_z});
    h  = ({{(HW-1){1'b0}}, half_width} > (HW+1)'(MAX_HALF)) ? (HW+1)'(MAX_HALF)
         : (HW+1)'(half_width);
  end

  function automatic logic [16:0] wsel(input logic [OW-1:0] off, input logic [16:0] a,
                                       input logic [16:0] b, input logic [16:0] c);
    logic [16:0] w;
    w = (off == '0) ? a : ((off == OW'(1)) ? b : c);
    return (w > 17'd65536) ? 17'd65536 : w;
  endfunction

  // position and state
  logic [8:0] px, py, pz;
  logic [6:0] zr;
  logic [8:0] cx, cy, cz;
  logic [OW-1:0] ta, tb, tc, tmax;
  logic [6:0] zbase;
  state_t state, state_next;
  logic emit, last;
  cell_in_t cin;

  logic [223:0] store [Depth];
  logic [223:0] rd;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wring, rring;

  assign tmax = OW'({h, 1'b0});
  assign wring = RW'(zr);
  assign waddr = AW'(AW'(wring) * AW'(MAX_SIZE_Y * MAX_SIZE_X)
                 + AW'(py[YW-1:0]) * AW'(MAX_SIZE_X) + AW'(px[XW-1:0]));

  logic [8:0] rx, ry;
  logic [7:0] rz;
  logic [RW-1:0] rzm;
  always_comb begin
    rx = cx + 9'(ta) - 9'(h);
    ry = cy + 9'(tb) - 9'(h);
    rz = 8'(zbase) + 8'(tc);
    rzm = (rz >= 8'(Ring)) ? RW'(rz - 8'(Ring)) : RW'(rz);
  end
  assign rring = rzm;
  assign raddr = AW'(AW'(rring) * AW'(MAX_SIZE_Y * MAX_SIZE_X)
                 + AW'(ry[YW-1:0]) * AW'(MAX_SIZE_X) + AW'(rx[XW-1:0]));

  always_ff @(posedge clk) begin
    if (state == ST_WRITE) store[waddr] <= 224'(cin);
    rd <= store[raddr];
  end

  // tap weight and MAC datapath
  logic [33:0] wab;
  logic [31:0] twt;
  logic [16:0] tq;
  logic [63:0] dsum;
  logic signed [63:0] msum [3];
  logic signed [63:0] bsum [3];
  logic signed [63:0] prod [3];
  logic signed [63:0] bprod [3];
  logic [47:0] dprod;
  logic [1:0] lane;
  logic signed [63:0] ms;
  logic [63:0] mq;
  logic signed [31:0] velv [3];
  logic signed [31:0] magv [3];
  logic [31:0] qv [3];

  assign velv[0] = rd[191:160];
  assign velv[1] = rd[159:128];
  assign velv[2] = rd[127:96];
  assign magv[0] = rd[95:64];
  assign magv[1] = rd[63:32];
  assign magv[2] = rd[31:0];

  logic signed [63:0] mws [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      // floor(p*t/2^16) split as hi*t + (lo*t)>>16
      mws[j] = ($signed(prod[j]) >>> 16) * $signed({47'd0, tq})
               + $signed({32'd0, 32'((64'(prod[j][15:0]) * 64'(tq)) >> 16)});
    end
  end

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return 64'sh7fffffffffffffff;
    if (a[63] && b[63] && !s[63]) return 64'sh8000000000000000;
    return s;
  endfunction

  logic div_start, div_busy;
  logic [31:0] div_q;
  mwsf_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(ms), .den(dsum),
    .busy(div_busy), .quo(div_q)
  );

  logic out_valid;
  logic out_free;
  cell_out_t res;
  assign out_res.valid = out_valid;
  assign out_res.data = res;
  assign in_cell.ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_res.ready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  logic tap_last;
  assign tap_last = (ta == tmax) && (tb == tmax) && (tc == tmax);

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    case (state)
      ST_IDLE:   if (in_cell.valid && in_cell.ready) state_next = ST_WRITE;
      ST_WRITE:  state_next = emit ? ST_RD : ST_IDLE;
      ST_RD:     state_next = ST_WT;
      ST_WT:     state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_ACC;
      ST_ACC:    state_next = tap_last ? ST_DIV : ST_RD;
      ST_DIV:    begin div_start = (dsum != '0); state_next = ST_DIVRUN; end
      ST_DIVRUN: if (!div_busy) state_next = (lane == 2'd2) ? ST_OUT : ST_DIV;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (lane)
      2'd0:    ms = msum[0];
      2'd1:    ms = msum[1];
      default: ms = msum[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0; py <= '0; pz <= '0; zr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_res.ready) out_valid <= 1'b0;
      if (state == ST_IDLE && in_cell.valid && in_cell.ready) begin
        cin <= in_cell.data;
        emit <= (px < sx) && (py < sy) && (pz < sz) && (px >= 9'({h, 1'b0}))
                && (py >= 9'({h, 1'b0})) && (pz >= 9'({h, 1'b0}));
        last <= (px == sx - 9'd1) && (py == sy - 9'd1) && (pz == sz - 9'd1);
        cx <= px - 9'(h); cy <= py - 9'(h); cz <= pz - 9'(h);
        zbase <= (zr >= 7'(h) * 7'd2) ? zr - 7'(h) * 7'd2 : zr + 7'(Ring) - 7'(h) * 7'd2;
      end
      if (state == ST_WRITE) begin
        ta <= '0; tb <= '0; tc <= '0; lane <= 2'd0;
        dsum <= '0;
        for (int j = 0; j < 3; j++) begin msum[j] <= '0; bsum[j] <= '0; end
        if (px + 9'd1 >= sx) begin
          px <= '0;
          if (py + 9'd1 >= sy) begin
            py <= '0;
            if (pz + 9'd1 >= sz) begin pz <= '0; zr <= '0; end
            else begin
              pz <= pz + 9'd1;
              zr <= (zr == 7'(Ring - 1)) ? '0 : zr + 7'd1;
            end
          end else py <= py + 9'd1;
        end else px <= px + 9'd1;
      end
      if (state == ST_WT) wab <= wsel(ta > OW'(h) ? ta - OW'(h) : OW'(h) - ta, w0, w1, w2)
                               * wsel(tb > OW'(h) ? tb - OW'(h) : OW'(h) - tb, w0, w1, w2);
      if (state == ST_MUL1) begin
        twt <= 32'(((64'(wab) * 64'(wsel(tc > OW'(h) ? tc - OW'(h) : OW'(h) - tc,
                    w0, w1, w2))) + 64'h80000000) >> 32);
        for (int j = 0; j < 3; j++)
          prod[j] <= $signed({33'd0, rd[222:192]}) * 64'(velv[j]);
      end
      if (state == ST_MUL2) begin
        tq <= twt[16:0];
        dprod <= 48'(rd[222:192]) * 48'(twt[16:0]);
        for (int j = 0; j < 3; j++) bprod[j] <= 64'(magv[j]) * $signed({47'd0, twt[16:0]});
      end
      if (state == ST_ACC) begin
        dsum <= dsum + 64'(dprod);
        for (int j = 0; j < 3; j++) begin
          msum[j] <= sadd(msum[j], mws[j]);
          if (mhd) bsum[j] <= bsum[j] + bprod[j];
        end
        if (ta != tmax) ta <= ta + OW'(1);
        else begin
          ta <= '0;
          if (tb != tmax) tb <= tb + OW'(1);
          else begin tb <= '0; tc <= tc + OW'(1); end
        end
      end
      if (state == ST_DIVRUN && !div_busy) begin
        qv[lane] <= (dsum == '0) ? 32'd0 : div_q;
        lane <= lane + 2'd1;
      end
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
        res.flt_density <= (((dsum + Round) >> DefFracBits) > 64'h7fffffff) ? 31'h7fffffff
                           : 31'((dsum + Round) >> DefFracBits);
        res.flt_vel_x <= qv[0];
        res.flt_vel_y <= qv[1];
        res.flt_vel_z <= qv[2];
        res.flt_mag_x <= mhd ? sat32((bsum[0] + 64'sd32768) >>> 16) : 32'd0;
        res.flt_mag_y <= mhd ? sat32((bsum[1] + 64'sd32768) >>> 16) : 32'd0;
        res.flt_mag_z <= mhd ? sat32((bsum[2] + 64'sd32768) >>> 16) : 32'd0;
        res.cell_x <= cx[5:0];
        res.cell_y <= cy[5:0];
        res.cell_z <= cz[5:0];
        res.zero_mass <= (dsum == '0);
        res.last_cell <= last;
      end
    end
  end

  assign mq = dsum;

  `include "mass_weighted_3d_stencil_filter_assert.svh"
  `MWSF_ASSERT_IMP(a_busy_not_ready, clk, rst, state != ST_IDLE, !in_cell.ready)
  `MWSF_ASSERT_NXT(a_out_sets, clk, rst, state == ST_OUT, out_valid)
  `MWSF_ASSERT_IMP(a_div_idle, clk, rst, div_start, !div_busy && mq != '0)
endmodule
